/* src/plie_pkg.sv */
// Shared types and codes for the point list insert/erase unit.
package plie_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } plie_pt_t;

  // ins: shift up from idx and write new point at idx
  // del: shift down from idx
  // rd:  request reads the entry at idx
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } plie_cmd_t;

endpackage

/* src/plie_cell.sv */
// One list entry cell: holds a point and moves it to or from its neighbors.
module plie_cell import plie_pkg::*; #(
  parameter int IDX_W = 5,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  plie_cmd_t        cmd,
  input  logic [IDX_W-1:0] idx,
  input  plie_pt_t         new_pt,
  input  plie_pt_t         left_pt,
  input  plie_pt_t         right_pt,
  output plie_pt_t         pt_q,
  output plie_pt_t         rd_pt
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  plie_pt_t pt_r;
  plie_pt_t pt_nxt;

  always_comb begin
    pt_nxt = pt_r;
    if (cmd.ins) begin
      if (MY_IDX > idx) begin
        pt_nxt = left_pt;
      end else if (MY_IDX == idx) begin
        pt_nxt = new_pt;
      end
    end else if (cmd.del) begin
      if (MY_IDX >= idx) begin
        pt_nxt = right_pt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign pt_q  = pt_r;
  assign rd_pt = (MY_IDX == idx) ? pt_r : '0;

endmodule

/* src/plie_ctrl.sv */
// Request decode, range checks and the element count register.
module plie_ctrl import plie_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [2:0]       op,
  input  logic [POS_W-1:0] pos,
  output plie_cmd_t        cmd,
  output logic [IDX_W-1:0] idx,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] count_nxt
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic             is_full;
  logic             is_empty;
  logic             ins;
  logic             del;
  logic             rd;

  assign pos_w    = CMP_W'(pos);
  assign cnt_w    = CMP_W'(count_r);
  assign is_full  = (cnt_w == CMP_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    ins       = 1'b0;
    del       = 1'b0;
    rd        = 1'b0;
    idx       = IDX_W'(pos_w);
    unique case (op)
      OP_APPEND: begin
        idx = IDX_W'(cnt_w);
        if (is_full) begin
          status = ST_FULL;
        end else begin
          ins       = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      OP_INSERT: begin
        // position equal to the count appends
        if (pos_w > cnt_w) begin
          status = ST_BADPOS;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          ins       = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_ERASE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          del       = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_BADPOS;
        end else begin
          rd = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd = '{ins: ins & go, del: del & go, rd: rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (go) begin
      count_r <= count_nxt;
    end
  end

endmodule

/* src/point_list_insert_erase_unit.sv */
// Top level of the point list insert/erase unit: cell chain, control and result register.
//
//   channel | direction | ports
//   in_     | input     | in_valid, in_ready, in_operation, in_position, in_point_x, in_point_y
//   out_    | output    | out_valid, out_ready, out_status, out_element_count, out_read_x,
//           |           | out_read_y
//
// One request per cycle while in_ready is high; every cell of the chain updates in the cycle it is accepted.
// The result is registered and appears in the cycle after acceptance.
// in_ready drops only while a result waits in the output register and out_ready is low.
// Synchronous reset empties the list; cell contents are not cleared.
module point_list_insert_erase_unit import plie_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_operation,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [31:0]        in_point_x,
  input  logic signed [31:0]        in_point_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_element_count,
  output logic signed [31:0]        out_read_x,
  output logic signed [31:0]        out_read_y
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             go;
  plie_cmd_t        cmd;
  logic [IDX_W-1:0] idx;
  logic [1:0]       status;
  logic [CNT_W-1:0] count_nxt;
  plie_pt_t         new_pt;
  plie_pt_t         cell_pt [DEPTH];
  plie_pt_t         cell_rd [DEPTH];
  plie_pt_t         rd_pt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  plie_pt_t           out_pt_r;

  assign in_ready = !out_valid_r || out_ready;
  assign go       = in_valid && in_ready;
  assign new_pt.x = in_point_x;
  assign new_pt.y = in_point_y;

  plie_ctrl #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .op       (in_operation),
    .pos      (in_position),
    .cmd      (cmd),
    .idx      (idx),
    .status   (status),
    .count_nxt(count_nxt)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    plie_pt_t left_pt;
    plie_pt_t right_pt;

    if (i == 0) begin : g_first
      assign left_pt = '0;
    end else begin : g_mid_l
      assign left_pt = cell_pt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_pt = '0;
    end else begin : g_mid_r
      assign right_pt = cell_pt[i+1];
    end

    plie_cell #(
      .IDX_W(IDX_W),
      .IDX  (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (idx),
      .new_pt  (new_pt),
      .left_pt (left_pt),
      .right_pt(right_pt),
      .pt_q    (cell_pt[i]),
      .rd_pt   (cell_rd[i])
    );
  end

  // only the addressed cell drives a nonzero value
  always_comb begin
    rd_pt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_pt = rd_pt | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= status;
      out_count_r  <= COUNT_W'(count_nxt);
      out_pt_r     <= cmd.rd ? rd_pt : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;
  assign out_read_x        = out_pt_r.x;
  assign out_read_y        = out_pt_r.y;

endmodule

/* src/plie_chk.sv */
// Port-level checker for the point list insert/erase unit, bound to the top level.
module plie_chk import plie_pkg::*; #(
  parameter int DEPTH = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_status,
  input logic [COUNT_W-1:0]  out_element_count,
  input logic signed [31:0]  out_read_x,
  input logic signed [31:0]  out_read_y
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_element_count) && $stable(out_read_x) && $stable(out_read_y))
    else $error("result changed while stalled");

  // every accepted request shows a result in the next cycle
  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // input side only stalls while a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // refused requests return no point
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_read_x == 0) && (out_read_y == 0))
    else $error("refused request returned point data");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_element_count) <= 32'(DEPTH))
    else $error("element count above capacity");

endmodule

bind point_list_insert_erase_unit plie_chk #(
  .DEPTH(DEPTH)
) u_plie_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_element_count(out_element_count),
  .out_read_x       (out_read_x),
  .out_read_y       (out_read_y)
);

/* tb/sv/tb_point_list_insert_erase_unit.sv */
// Self-checking testbench for the point list insert/erase unit.
`timescale 1ns / 100ps

module tb_point_list_insert_erase_unit;
  import plie_pkg::*;

  localparam int LIST_DEPTH   = 32;
  localparam int STALL_CYCLES = 400;
  localparam int LIMIT_CYCLES = 300000;

  // codes with no defined operation; the unit must ignore them
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
  } list_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_operation = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic signed [31:0]  in_point_x = '0;
  logic signed [31:0]  in_point_y = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic [COUNT_W-1:0]  out_element_count;
  logic signed [31:0]  out_read_x;
  logic signed [31:0]  out_read_y;

  // shadow copy of the list, updated when a request is accepted
  plie_pt_t     shadow_pts [LIST_DEPTH];
  int           shadow_cnt = 0;
  list_result_t pending_results [$];
  list_result_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stalling = 1'b0;
  event stall_go;

  int mismatch_cnt = 0;
  int result_cnt = 0;
  int cycle_cnt = 0;
  int op_seen [8];
  int status_seen [4];

  point_list_insert_erase_unit #(.DEPTH(LIST_DEPTH)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_read_x        (out_read_x),
    .out_read_y        (out_read_y)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("point_list_insert_erase_unit test failed");
      $finish;
    end
  end

  // receiver: random idling, forced low during a long stall
  always @(negedge clk) begin
    out_ready <= !stalling && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    forever begin
      @(stall_go);
      stalling = 1'b1;
      repeat (STALL_CYCLES) @(posedge clk);
      stalling = 1'b0;
    end
  end

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    list_result_t res;
    int p;
    int i;
    p = int'(pos);
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_cnt >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_pts[shadow_cnt].x = x;
          shadow_pts[shadow_cnt].y = y;
          shadow_cnt++;
        end
      end
      OP_REMOVE: begin
        if (shadow_cnt == 0) res.status = ST_EMPTY;
        else shadow_cnt--;
      end
      OP_INSERT: begin
        // position check wins over the full check
        if (p > shadow_cnt) begin
          res.status = ST_BADPOS;
        end else if (shadow_cnt >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_cnt; i > p; i--) shadow_pts[i] = shadow_pts[i-1];
          shadow_pts[p].x = x;
          shadow_pts[p].y = y;
          shadow_cnt++;
        end
      end
      OP_ERASE: begin
        if (shadow_cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= shadow_cnt) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = p; i + 1 < shadow_cnt; i++) shadow_pts[i] = shadow_pts[i+1];
          shadow_cnt--;
        end
      end
      OP_READ: begin
        if (shadow_cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= shadow_cnt) begin
          res.status = ST_BADPOS;
        end else begin
          res.rx = shadow_pts[p].x;
          res.ry = shadow_pts[p].y;
        end
      end
      OP_CLEAR: shadow_cnt = 0;
      default: ;
    endcase
    res.count = COUNT_W'(shadow_cnt);
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // drive one request from the falling edge and wait until it is taken
  task automatic send_req(input logic [2:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [31:0] x, input logic signed [31:0] y);
    list_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_point_x   <= x;
    in_point_y   <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_list_op(op, pos, x, y);
    pending_results = {pending_results, res};
    op_seen[op]++;
    status_seen[res.status]++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("result %0d with no request pending: st=%0d cnt=%0d x=%0d y=%0d",
                   result_cnt, out_status, out_element_count, out_read_x, out_read_y);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_element_count !== want.count ||
            out_read_x !== want.rx || out_read_y !== want.ry) begin
          if (mismatch_cnt < 10)
            $display("mismatch at result %0d: exp st=%0d cnt=%0d x=%0d y=%0d, %s%0d %0d %0d %0d",
                     result_cnt, want.status, want.count, want.rx, want.ry,
                     "got st/cnt/x/y=", out_status, out_element_count,
                     out_read_x, out_read_y);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_req(OP_REMOVE, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_ERASE, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd31, 32'sd0, 32'sd0);
    send_req(OP_INSERT, 5'd1, 32'sd5, 32'sd6);
    send_req(OP_INSERT, 5'd31, 32'sd5, 32'sd6);
    send_req(OP_INSERT, 5'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_req(OP_READ, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd1, 32'sd0, 32'sd0);
    send_req(OP_REMOVE, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_REMOVE, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_UNUSED6, 5'd31, 32'shffff_ffff, 32'shffff_ffff);
    send_req(OP_UNUSED7, 5'd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_full_list();
    int k;
    send_req(OP_CLEAR, 5'd0, 32'sd0, 32'sd0);
    for (k = 0; k < LIST_DEPTH; k++)
      send_req(OP_APPEND, POS_W'(k), (k % 2) ? 32'sh7fff_ffff : 32'sh8000_0000 + k,
               32'sd1000 * k - 32'sd7);
    send_req(OP_APPEND, 5'd0, 32'sd1, 32'sd1);
    send_req(OP_INSERT, 5'd31, 32'sd1, 32'sd1);
    send_req(OP_INSERT, 5'd0, 32'sd1, 32'sd1);
    send_req(OP_READ, 5'd31, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_ERASE, 5'd31, 32'sd0, 32'sd0);
    send_req(OP_INSERT, 5'd31, 32'sd77, 32'sd88);
    send_req(OP_ERASE, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd30, 32'sd0, 32'sd0);
  endtask

  task automatic test_position_checks();
    send_req(OP_CLEAR, 5'd0, 32'sd0, 32'sd0);
    send_req(OP_APPEND, 5'd0, 32'sd10, 32'sd11);
    send_req(OP_APPEND, 5'd0, 32'sd20, 32'sd21);
    send_req(OP_APPEND, 5'd0, 32'sd30, 32'sd31);
    send_req(OP_INSERT, 5'd5, 32'sd1, 32'sd1);
    send_req(OP_INSERT, 5'd3, 32'sd40, 32'sd41);    // position equal to count appends
    send_req(OP_INSERT, 5'd0, 32'sd0, 32'sd1);
    send_req(OP_ERASE, 5'd5, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd5, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd4, 32'sd0, 32'sd0);
    send_req(OP_ERASE, 5'd1, 32'sd0, 32'sd0);
    send_req(OP_READ, 5'd1, 32'sd0, 32'sd0);
    send_req(OP_UNUSED6, 5'd2, 32'sd0, 32'sd0);
    send_req(OP_UNUSED7, 5'd16, 32'sd0, 32'sd0);
    send_req(OP_CLEAR, 5'd31, 32'sd0, 32'sd0);
    send_req(OP_CLEAR, 5'd0, 32'sd0, 32'sd0);
  endtask

  // mostly legal positions; grow, shrink and mixed stretches push the list to both ends
  task automatic test_random_traffic(input int n);
    int k;
    int mode;
    int roll;
    int pos;
    logic [2:0] op;
    mode = 0;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        op  = 3'($urandom_range(0, 7));
        pos = $urandom_range(0, 31);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
          op = OP_CLEAR;
        end else begin
          case (mode)
            0: op = (roll < 35) ? OP_APPEND : (roll < 70) ? OP_INSERT :
                    (roll < 85) ? OP_READ : (roll < 93) ? OP_ERASE : OP_REMOVE;
            1: op = (roll < 8) ? OP_APPEND : (roll < 16) ? OP_INSERT :
                    (roll < 36) ? OP_READ : (roll < 70) ? OP_ERASE : OP_REMOVE;
            default: op = (roll < 20) ? OP_APPEND : (roll < 40) ? OP_INSERT :
                          (roll < 65) ? OP_READ : (roll < 85) ? OP_ERASE : OP_REMOVE;
          endcase
        end
        if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 31);
        else if (op == OP_INSERT) pos = $urandom_range(0, (shadow_cnt > 31) ? 31 : shadow_cnt);
        else if (shadow_cnt > 0) pos = $urandom_range(0, shadow_cnt - 1);
        else pos = $urandom_range(0, 31);
      end
      send_req(op, POS_W'(pos), rand_coord(), rand_coord());
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    -> stall_go;
    for (k = 0; k < 60; k++)
      send_req((k % 3 == 0) ? OP_READ : OP_APPEND, POS_W'(k % 8), rand_coord(), rand_coord());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 71;
    test_empty_list();
    test_full_list();
    test_position_checks();
    test_random_traffic(600);
    drain_results();

    send_idle_pct = 71;
    recv_idle_pct = 16;
    test_random_traffic(600);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(600);
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk);

    $write("ran %0d requests: %0d append, %0d remove, %0d insert, ",
           op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3] + op_seen[4] + op_seen[5] +
           op_seen[6] + op_seen[7], op_seen[OP_APPEND], op_seen[OP_REMOVE],
           op_seen[OP_INSERT]);
    $display("%0d erase, %0d read, %0d clear, %0d undefined",
             op_seen[OP_ERASE], op_seen[OP_READ], op_seen[OP_CLEAR],
             op_seen[OP_UNUSED6] + op_seen[OP_UNUSED7]);
    $display("outcomes: %0d ok, %0d full, %0d empty, %0d bad position; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADPOS], mismatch_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("point_list_insert_erase_unit test passed");
    end else begin
      $display("point_list_insert_erase_unit test failed");
    end
    $finish;
  end

endmodule
